>>> hw/rtl/calt_pkg.sv
// shared types, constants and the month length table for the calendar time adder
package calt_pkg;

  localparam int YEAR_BITS = 16;
  localparam int YEAR_RESET = 2026;
  localparam int GIVEN_YEAR_W = 16;
  localparam int CMP_YEAR_W = (YEAR_BITS > GIVEN_YEAR_W) ? YEAR_BITS : GIVEN_YEAR_W;

  localparam int MIN_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MONTHS = 12;

  // width of the running minute, hour and day sums
  localparam int ACC_W = 17;
  // reciprocals for floor(x / 60) and floor(x / 24), exact for any ACC_W-bit x
  localparam int MUL_W = 18;
  localparam int PROD_W = ACC_W + MUL_W;
  localparam int DIV60_MUL = 139811;
  localparam int DIV60_SHIFT = 23;
  localparam int DIV24_MUL = 174763;
  localparam int DIV24_SHIFT = 22;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_CMP  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  given_day;
    logic [3:0]  given_month;
    logic [15:0] given_year;
    logic [4:0]  given_hours;
    logic [5:0]  given_minutes;
    logic [15:0] add_days;
    logic [15:0] add_hours;
    logic [15:0] add_minutes;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic [4:0]  cur_hours;
    logic [5:0]  cur_minutes;
    logic        later_flag;
  } out_item_t;

  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
  } stamp_t;

  // no leap years; invalid month codes count as 31 days
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] d;
    case (month)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/calt_sub.sv
// shared subtract and compare unit used by the divider steps and the month walk
module calt_sub (
  input  logic [calt_pkg::ACC_W-1:0] a,
  input  logic [calt_pkg::ACC_W-1:0] b,
  output logic [calt_pkg::ACC_W-1:0] diff,
  output logic                       ge
);
  import calt_pkg::*;

  logic [ACC_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[ACC_W-1:0];
  assign ge   = ~full[ACC_W];

endmodule

>>> hw/rtl/calt_cmp.sv
// ordered compare of the stored timestamp against the given one
module calt_cmp (
  input  calt_pkg::stamp_t   stored,
  input  calt_pkg::in_item_t given,
  output logic               later
);
  import calt_pkg::*;

  logic [CMP_YEAR_W-1:0] sy;
  logic [CMP_YEAR_W-1:0] gy;

  assign sy = CMP_YEAR_W'(stored.year);
  assign gy = CMP_YEAR_W'(given.given_year);

  always_comb begin
    if (sy != gy) begin
      later = sy > gy;
    end else if (stored.month != given.given_month) begin
      later = stored.month > given.given_month;
    end else if (stored.day != given.given_day) begin
      later = stored.day > given.given_day;
    end else if (stored.hour != given.given_hours) begin
      later = stored.hour > given.given_hours;
    end else begin
      later = stored.minute > given.given_minutes;
    end
  end

endmodule

>>> hw/rtl/calendar_time_adder.sv
// calendar time adder: sequencer, timestamp registers and result register
//
//   port group   dir   handshake             payload
//   in_          in    in_valid / in_ready   in_data  (calt_pkg::in_item_t)
//   out_         out   out_valid / out_ready out_data (calt_pkg::out_item_t)
//
// load, compare and the unused command go from S_IDLE straight to S_OUT.
// add divides by 60 and by 24, each as a reciprocal multiply (S_MDIV, S_HDIV) and
// a remainder on the shared subtractor (S_MREM, S_HREM), then a month walk, one month
// per cycle on the shared subtractor (S_WALK), before S_OUT.
// one item at a time: in_ready is high only when no item is in flight.
// the result holds in out_data until out_ready takes it; reset is synchronous.
module calendar_time_adder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  calt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output calt_pkg::out_item_t  out_data
);
  import calt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MDIV = 7'b0000010,
    S_MREM = 7'b0000100,
    S_HDIV = 7'b0001000,
    S_HREM = 7'b0010000,
    S_WALK = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  stamp_t               ts_r, ts_nxt;
  in_item_t             item_r, item_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     quot_r, quot_nxt;
  logic                 flag_r, flag_nxt;

  logic [ACC_W-1:0]     sub_a, sub_b, sub_diff;
  logic                 sub_ge;
  logic                 later;
  logic [MUL_W-1:0]     recip;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     quot_calc;
  logic [3:0]           month_inc;

  calt_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  calt_cmp u_cmp (
    .stored (ts_r),
    .given  (in_data),
    .later  (later)
  );

  // operand select for the shared subtractor
  always_comb begin
    sub_a = acc_r;
    sub_b = ACC_W'(month_days(ts_r.month));
    case (state_r)
      S_MREM: begin
        sub_b = quot_r * ACC_W'(MIN_PER_HOUR);
      end
      S_HREM: begin
        sub_b = quot_r * ACC_W'(HOURS_PER_DAY);
      end
      default: begin
        sub_b = ACC_W'(month_days(ts_r.month));
      end
    endcase
  end

  // quotient by reciprocal multiply, remainder on the subtractor next cycle
  assign recip     = (state_r == S_HDIV) ? MUL_W'(DIV24_MUL) : MUL_W'(DIV60_MUL);
  assign prod      = PROD_W'(acc_r) * PROD_W'(recip);
  assign quot_calc = (state_r == S_HDIV) ? ACC_W'(prod >> DIV24_SHIFT)
                                         : ACC_W'(prod >> DIV60_SHIFT);
  assign month_inc = ts_r.month + 4'd1;

  always_comb begin
    state_nxt = state_r;
    ts_nxt    = ts_r;
    item_nxt  = item_r;
    acc_nxt   = acc_r;
    quot_nxt  = quot_r;
    flag_nxt  = flag_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          flag_nxt  = 1'b0;
          state_nxt = S_OUT;
          case (in_data.command)
            CMD_LOAD: begin
              ts_nxt.year   = YEAR_BITS'(in_data.given_year);
              ts_nxt.month  = in_data.given_month;
              ts_nxt.day    = in_data.given_day;
              ts_nxt.hour   = in_data.given_hours;
              ts_nxt.minute = in_data.given_minutes;
            end
            CMD_ADD: begin
              acc_nxt   = ACC_W'(ts_r.minute) + ACC_W'(in_data.add_minutes);
              state_nxt = S_MDIV;
            end
            CMD_CMP: begin
              flag_nxt = later;
            end
            default: begin
              flag_nxt = 1'b0;
            end
          endcase
        end
      end
      S_MDIV: begin
        quot_nxt  = quot_calc;
        state_nxt = S_MREM;
      end
      S_MREM: begin
        ts_nxt.minute = sub_diff[5:0];
        acc_nxt   = ACC_W'(ts_r.hour) + quot_r + ACC_W'(item_r.add_hours);
        state_nxt = S_HDIV;
      end
      S_HDIV: begin
        quot_nxt  = quot_calc;
        state_nxt = S_HREM;
      end
      S_HREM: begin
        ts_nxt.hour = sub_diff[4:0];
        acc_nxt     = ACC_W'(ts_r.day) + quot_r + ACC_W'(item_r.add_days);
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        // step a month while the day count overruns the current month
        if (sub_ge && (sub_diff != '0)) begin
          acc_nxt = sub_diff;
          if (month_inc > 4'(MONTHS)) begin
            ts_nxt.month = 4'd1;
            ts_nxt.year  = ts_r.year + YEAR_BITS'(1);
          end else begin
            ts_nxt.month = month_inc;
          end
        end else begin
          ts_nxt.day = acc_r[4:0];
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ts_r.year <= YEAR_BITS'(YEAR_RESET);
      ts_r.month  <= 4'd1;
      ts_r.day    <= 5'd1;
      ts_r.hour   <= 5'd0;
      ts_r.minute <= 6'd0;
    end else begin
      state_r <= state_nxt;
      ts_r    <= ts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    acc_r  <= acc_nxt;
    quot_r <= quot_nxt;
    flag_r <= flag_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    out_data.cur_day     = ts_r.day;
    out_data.cur_month   = ts_r.month;
    out_data.cur_year    = 16'(ts_r.year);
    out_data.cur_hours   = ts_r.hour;
    out_data.cur_minutes = ts_r.minute;
    out_data.later_flag  = flag_r;
  end

endmodule
